// ===== sv/swmm_pkg.sv =====
// Package: shared constants, types and helper functions of the sliding window min/max filter.
`timescale 1ns / 1ps

package swmm_pkg;

  localparam int unsigned MAX_HALF   = 15;
  localparam int unsigned WIN_LEN    = 2 * MAX_HALF + 1;
  localparam int unsigned TREE_N     = 32;
  localparam int unsigned TREE_MID   = 4;
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned HALF_W     = 4;
  localparam int unsigned CNT_W      = $clog2(WIN_LEN + 1);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(1);

  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic mode;
  } tree_ctrl_t;

  function automatic sample_t pick(input sample_t a, input sample_t b, input logic mode);
    if (mode == MODE_MAX) begin
      return (b > a) ? b : a;
    end else begin
      return (b < a) ? b : a;
    end
  endfunction

  function automatic sample_t neutral(input logic mode);
    return (mode == MODE_MAX) ? '0 : '1;
  endfunction

endpackage

// ===== sv/swmm_if.sv =====
// Interfaces: sample input, filtered output and register write channels.
`timescale 1ns / 1ps

interface swmm_in_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface swmm_out_if;
  import swmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    last_res;
  modport source (output valid, output filtered, output last_res, input ready);
  modport sink   (input valid, input filtered, input last_res, output ready);
endinterface

interface swmm_cfg_if;
  import swmm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sliding_window_min_max_filter.sv =====
// Top level: sliding window min/max filter with a chain of window cells and a comparator tree.
`timescale 1ns / 1ps

// Takes 8-bit samples and gives the minimum (mode 0) or maximum (mode 1) over a centred
// window of 2*half_width+1 samples, clipped at both ends of a signal; results lag the input
// by half_width samples, and the sample marked last flushes the rest of the signal. One item
// at a time: a sample is taken only in the idle state, and one that gives no result leaves
// the block idle; each result passes S_RED_A and S_RED_B (the two comparator tree stages)
// and then S_OUT, where it waits for the sink; a last sample gives min(H, n-1)+1 results.
// Register writes take effect with the first sample of the next signal.

module sliding_window_min_max_filter
  import swmm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  swmm_in_if.sink    in_i,
  swmm_out_if.source out_o,
  swmm_cfg_if.sink   cfg_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [HALF_W-1:0] half_width_q;
  logic              mode_q;
  logic [HALF_W-1:0] act_half_q;
  logic              act_mode_q;
  cnt_t              cnt_q;
  cnt_t              k_q;
  cnt_t              lim_q;
  logic              flush_q;
  logic              out_valid_q;
  logic              last_res_q;

  logic              in_xfer;
  logic [HALF_W-1:0] half_d;
  logic              mode_d;
  cnt_t              cnt_d;
  cnt_t              newest;
  cnt_t              half_ext;
  cnt_t              k_d;
  cnt_t              lim_d;
  logic              has_res;

  sample_t           chain [WIN_LEN+1];
  sample_t           cand [TREE_N];
  tree_ctrl_t        tree_ctrl;
  sample_t           tree_res;

  assign in_xfer     = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (cnt_q == '0) begin
      half_d = (32'(half_width_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : half_width_q;
      mode_d = mode_q;
    end else begin
      half_d = act_half_q;
      mode_d = act_mode_q;
    end
    cnt_d    = (cnt_q == CNT_W'(WIN_LEN)) ? cnt_q : cnt_q + 1'b1;
    newest   = cnt_d - 1'b1;
    half_ext = CNT_W'(half_d);
    k_d      = (half_ext < newest) ? half_ext : newest;
    lim_d    = in_i.last ? k_d + half_ext : CNT_W'({half_ext, 1'b0});
    has_res  = in_i.last || (cnt_d > half_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      half_width_q <= HALF_W'(1);
      mode_q       <= MODE_MIN;
      act_half_q   <= HALF_W'(1);
      act_mode_q   <= MODE_MIN;
      cnt_q        <= '0;
      k_q          <= '0;
      lim_q        <= '0;
      flush_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      last_res_q   <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_HALF_WIDTH: half_width_q <= cfg_i.data[HALF_W-1:0];
          REG_MODE:       mode_q       <= cfg_i.data[0];
          default:        ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            act_half_q <= half_d;
            act_mode_q <= mode_d;
            cnt_q      <= cnt_d;
            k_q        <= k_d;
            lim_q      <= lim_d;
            flush_q    <= in_i.last;
            if (has_res) begin
              state_q <= S_RED_A;
            end
          end
        end
        S_RED_A: begin
          state_q <= S_RED_B;
        end
        S_RED_B: begin
          out_valid_q <= 1'b1;
          last_res_q  <= flush_q && (k_q == '0);
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (flush_q && (k_q != '0)) begin
              k_q     <= k_q - 1'b1;
              lim_q   <= lim_q - 1'b1;
              state_q <= S_RED_A;
            end else begin
              if (flush_q) begin
                cnt_q   <= '0;
                flush_q <= 1'b0;
              end
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign chain[0] = in_i.sample;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    swmm_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (in_xfer),
      .sample_i (chain[i]),
      .pos_i    (CNT_W'(i)),
      .lim_i    (lim_q),
      .cnt_i    (cnt_q),
      .mode_i   (act_mode_q),
      .sample_o (chain[i+1]),
      .cand_o   (cand[i])
    );
  end

  for (genvar i = WIN_LEN; i < TREE_N; i++) begin : g_pad
    assign cand[i] = neutral(act_mode_q);
  end

  assign tree_ctrl.load_a = (state_q == S_RED_A);
  assign tree_ctrl.load_b = (state_q == S_RED_B);
  assign tree_ctrl.mode   = act_mode_q;

  swmm_tree u_tree (
    .clk_i  (clk_i),
    .ctrl_i (tree_ctrl),
    .cand_i (cand),
    .res_o  (tree_res)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = tree_res;
  assign out_o.last_res = last_res_q;

endmodule

// ===== sv/swmm_cell.sv =====
// Window cell: one stored sample, shifted on from its neighbour, masked to the active window.
`timescale 1ns / 1ps

module swmm_cell
  import swmm_pkg::*;
(
  input  logic    clk_i,
  input  logic    shift_i,
  input  sample_t sample_i,
  input  cnt_t    pos_i,
  input  cnt_t    lim_i,
  input  cnt_t    cnt_i,
  input  logic    mode_i,
  output sample_t sample_o,
  output sample_t cand_o
);

  sample_t sample_q;
  logic    incl;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign incl     = (pos_i <= lim_i) && (pos_i < cnt_i);
  assign sample_o = sample_q;
  assign cand_o   = incl ? sample_q : neutral(mode_i);

endmodule

// ===== sv/swmm_tree.sv =====
// Comparator tree: two registered stages reducing the cell candidates to one min or max.
`timescale 1ns / 1ps

module swmm_tree
  import swmm_pkg::*;
(
  input  logic       clk_i,
  input  tree_ctrl_t ctrl_i,
  input  sample_t    cand_i [TREE_N],
  output sample_t    res_o
);

  sample_t l1 [16];
  sample_t l2 [8];
  sample_t l3 [TREE_MID];
  sample_t mid_q [TREE_MID];
  sample_t m1 [2];
  sample_t res_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      l1[i] = pick(cand_i[2*i], cand_i[2*i+1], ctrl_i.mode);
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = pick(l1[2*i], l1[2*i+1], ctrl_i.mode);
    end
    for (int i = 0; i < TREE_MID; i++) begin
      l3[i] = pick(l2[2*i], l2[2*i+1], ctrl_i.mode);
    end
    for (int i = 0; i < 2; i++) begin
      m1[i] = pick(mid_q[2*i], mid_q[2*i+1], ctrl_i.mode);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_a) begin
      mid_q <= l3;
    end
    if (ctrl_i.load_b) begin
      res_q <= pick(m1[0], m1[1], ctrl_i.mode);
    end
  end

  assign res_o = res_q;

endmodule

// ===== verif/tb_sliding_window_min_max_filter.sv =====
// Testbench: random and directed streams through the sliding window min/max filter, self-checked.
`timescale 1ns / 1ps

module tb_sliding_window_min_max_filter;
  import swmm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    sample_t filtered;
    logic    last_res;
  } filt_res_t;

  class window_filter_calc;
    logic [HALF_W-1:0] half_reg;
    logic              mode_reg;
    logic [HALF_W-1:0] run_half;
    logic              run_mode;
    sample_t           win[WIN_LEN];
    int unsigned       count;
    filt_res_t         awaited[$];
    int unsigned       errors;

    function new();
      half_reg = HALF_W'(1);
      mode_reg = MODE_MIN;
      run_half = HALF_W'(1);
      run_mode = MODE_MIN;
      count    = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_HALF_WIDTH) begin
        half_reg = d[HALF_W-1:0];
      end else if (idx == REG_MODE) begin
        mode_reg = d[0];
      end
    endfunction

    function sample_t window_extreme(int unsigned hi);
      sample_t acc;
      acc = win[0];
      for (int unsigned i = 1; i <= hi && i < WIN_LEN; i++) begin
        if (run_mode == MODE_MAX) begin
          if (win[i] > acc) acc = win[i];
        end else begin
          if (win[i] < acc) acc = win[i];
        end
      end
      return acc;
    endfunction

    function void take_sample(sample_t s, logic is_last);
      int unsigned newest;
      int unsigned h;
      int unsigned k;
      int unsigned hi;
      filt_res_t   r;
      if (count == 0) begin
        run_half = (half_reg > MAX_HALF) ? HALF_W'(MAX_HALF) : half_reg;
        run_mode = mode_reg;
      end
      for (int i = WIN_LEN - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = s;
      if (count < WIN_LEN) count++;
      newest = count - 1;
      h = run_half;
      if (!is_last) begin
        if (count > h) begin
          hi = (2 * h < newest) ? 2 * h : newest;
          r.filtered = window_extreme(hi);
          r.last_res = 1'b0;
          awaited.push_back(r);
        end
      end else begin
        k = (h < newest) ? h : newest;
        forever begin
          hi = (k + h < newest) ? k + h : newest;
          r.filtered = window_extreme(hi);
          r.last_res = (k == 0);
          awaited.push_back(r);
          if (k == 0) break;
          k--;
        end
        count = 0;
      end
    endfunction

    function void check_filtered(sample_t got_f, logic got_l);
      filt_res_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: filtered %h last_res %b", got_f, got_l);
        return;
      end
      e = awaited.pop_front();
      if (got_f !== e.filtered || got_l !== e.last_res) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected filtered %h last_res %b, got filtered %h last_res %b",
                   e.filtered, e.last_res, got_f, got_l);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  swmm_in_if  in_bus ();
  swmm_out_if out_bus ();
  swmm_cfg_if cfg_bus ();

  sliding_window_min_max_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  window_filter_calc calc;
  int unsigned       samples_sent;
  int unsigned       in_gap_chance;
  int unsigned       out_stall_chance;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output side: take transfers and stall in bursts.
  initial begin
    int unsigned stall;
    stall = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        calc.check_filtered(out_bus.filtered, out_bus.last_res);
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else if (out_stall_chance != 0 && $urandom_range(99) < out_stall_chance) begin
        stall = $urandom_range(1, 15) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic sample_t rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'h00;
    if (r < 24) return 8'hFF;
    return sample_t'($urandom_range(0, 255));
  endfunction

  task automatic send_sample(input sample_t s, input logic is_last);
    if (in_gap_chance != 0 && $urandom_range(99) < in_gap_chance) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_bus.valid  <= 1'b1;
    in_bus.sample <= s;
    in_bus.last   <= is_last;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    calc.take_sample(s, is_last);
    samples_sent++;
  endtask

  // Hold until every awaited result has arrived and the block has gone quiet.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (calc.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    calc.set_reg(idx, d);
  endtask

  task automatic program_filter(input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] m,
                                input bit spare);
    write_reg(REG_HALF_WIDTH, h);
    write_reg(REG_MODE, m);
    if (spare)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                CFG_DATA_W'($urandom_range(0, 15)));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_signal(input sample_t s0, input sample_t s1, input sample_t s2,
                             input int unsigned len);
    sample_t vals[3];
    vals[0] = s0;
    vals[1] = s1;
    vals[2] = s2;
    for (int unsigned i = 0; i < len; i++) send_sample(vals[i], i == len - 1);
  endtask

  initial begin
    int unsigned target;
    int unsigned h;
    int unsigned len;
    int unsigned pause_at;
    int unsigned nsig;
    int unsigned r;
    calc = new();
    samples_sent     = 0;
    in_gap_chance    = 0;
    out_stall_chance = 0;
    rst_ni        <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.sample <= '0;
    in_bus.last   <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: minimum over three samples.
    send_sample(8'h00, 1'b0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'h55, 1'b0);
    send_sample(8'hAA, 1'b1);
    send_signal(8'hFF, 8'h00, 8'h00, 1);
    settle();

    // Zero half width, maximum; unused indexes must not disturb anything.
    write_reg(REG_SPARE_A, 4'hF);
    write_reg(REG_HALF_WIDTH, 4'h0);
    write_reg(REG_MODE, 4'h1);
    write_reg(REG_SPARE_B, 4'hF);
    cfg_bus.valid <= 1'b0;
    send_signal(8'h12, 8'hFF, 8'h00, 3);
    settle();

    // Widest window on a short signal: all results come at the last sample.
    program_filter(4'hF, 4'h0, 1'b0);
    send_signal(8'h80, 8'h01, 8'hFE, 3);
    settle();

    // Writes between signals take effect for the next signal.
    program_filter(4'h2, 4'hF, 1'b0);
    send_signal(8'h10, 8'h20, 8'h30, 3);
    settle();
    program_filter(4'h0, 4'hE, 1'b0);
    send_sample(8'h05, 1'b0);
    send_sample(8'h40, 1'b1);
    send_signal(8'h07, 8'h08, 8'h00, 2);
    send_signal(8'h00, 8'h00, 8'h00, 1);
    settle();

    target = samples_sent + 140;
    while (samples_sent < target) begin
      if (samples_sent + 30 >= target) begin
        in_gap_chance    = 0;
        out_stall_chance = 0;
      end else begin
        r = $urandom_range(0, 2);
        in_gap_chance    = (r == 0) ? 0 : (r == 1) ? 10 : 35;
        r = $urandom_range(0, 2);
        out_stall_chance = (r == 0) ? 0 : (r == 1) ? 10 : 35;
      end
      r = $urandom_range(0, 5);
      h = (r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(0, 15);
      settle();
      program_filter(CFG_DATA_W'(h), CFG_DATA_W'($urandom_range(0, 15)),
                     $urandom_range(0, 3) == 0);
      nsig = $urandom_range(1, 3);
      repeat (nsig) begin
        r = $urandom_range(0, 9);
        if (r == 0) len = 1;
        else if (r == 1) len = $urandom_range(32, 40);
        else len = $urandom_range(1, 2 * h + 4);
        pause_at = (len > 1 && $urandom_range(0, 6) == 0) ? $urandom_range(1, len - 1) : 0;
        for (int unsigned i = 0; i < len; i++) begin
          if (pause_at != 0 && i == pause_at) begin
            settle();
            program_filter(CFG_DATA_W'($urandom_range(0, 15)),
                           CFG_DATA_W'($urandom_range(0, 15)), 1'b0);
          end
          send_sample(rand_sample(), i == len - 1);
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (calc.errors == 0 && calc.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/swmm_pkg.sv
sv/swmm_if.sv
sv/swmm_cell.sv
sv/swmm_tree.sv
sv/sliding_window_min_max_filter.sv
verif/tb_sliding_window_min_max_filter.sv
